[hw/rtl/sphf_pkg.sv]
// ---------------------------------------------------------------------------
// Scattering phase function package
// Shared constants, types and lookup functions for the phase function pipeline.
// ---------------------------------------------------------------------------
package sphf_pkg;

  localparam int MAX_ANGLES = 1023;
  localparam logic [9:0] TS_MAX = 10'((MAX_ANGLES + 1) / 2);
  localparam logic [9:0] TS_MIN = 10'd2;
  localparam logic [9:0] TS_RESET = 10'd91;

  localparam int COS_LAT = 35;
  localparam int LOBE_LAT = 46;
  localparam int HORNER_STEPS = 8;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [28:0] INV4PI_Q32 = 29'd341782637;
  localparam logic [28:0] C38PI_Q32 = 29'd512673956;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [47:0] LOBE_CAP = 48'h8000_0000_0000;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_THETA_SAMPLES = 2'd1;

  typedef enum logic [1:0] {
    MODE_CS   = 2'd0,
    MODE_HG   = 2'd1,
    MODE_DHG  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] mu;
  } angle_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] value;
  } lobe_t;

  // Divisor n(n-1) of Horner step s, for n = 16 down to 2.
  function automatic logic [7:0] horner_div(input int s);
    logic [7:0] d;
    d = 8'd2;
    unique case (s)
      0: d = 8'd240;
      1: d = 8'd182;
      2: d = 8'd132;
      3: d = 8'd90;
      4: d = 8'd56;
      5: d = 8'd30;
      6: d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / n(n-1)) for Horner step s.
  function automatic logic [31:0] horner_recip(input int s);
    logic [31:0] m;
    m = 32'd2147483648;
    unique case (s)
      0: m = 32'd17895697;
      1: m = 32'd23598721;
      2: m = 32'd32537631;
      3: m = 32'd47721858;
      4: m = 32'd76695844;
      5: m = 32'd143165576;
      6: m = 32'd357913941;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/sphf_cos.sv]
// ---------------------------------------------------------------------------
// Angle cosine pipeline
// Folds the sample index, divides out the angle step and runs the Horner cosine.
// ---------------------------------------------------------------------------
module sphf_cos (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [9:0]      index,
  input  logic [9:0]      last,
  output sphf_pkg::angle_t angle
);
  import sphf_pkg::*;

  localparam int DIV_STAGES = 8;

  logic [9:0]  idx_c;
  logic [9:0]  fold_c;
  logic        neg_c;
  logic [41:0] num_c;
  logic        dv_valid [0:DIV_STAGES];
  logic        dv_neg   [0:DIV_STAGES];
  logic [41:0] dv_st    [0:DIV_STAGES];
  logic [63:0] zz_c;
  logic        y_valid;
  logic        y_neg;
  logic [31:0] y_val;
  logic        ha_valid [0:HORNER_STEPS-1];
  logic        ha_neg   [0:HORNER_STEPS-1];
  logic [31:0] ha_y     [0:HORNER_STEPS-1];
  logic [31:0] ha_x     [0:HORNER_STEPS-1];
  logic        hb_valid [0:HORNER_STEPS-1];
  logic        hb_neg   [0:HORNER_STEPS-1];
  logic [31:0] hb_y     [0:HORNER_STEPS-1];
  logic [31:0] hb_x     [0:HORNER_STEPS-1];
  logic [31:0] hb_q     [0:HORNER_STEPS-1];
  logic        hc_valid [0:HORNER_STEPS-1];
  logic        hc_neg   [0:HORNER_STEPS-1];
  logic [31:0] hc_y     [0:HORNER_STEPS-1];
  logic [30:0] hc_t     [0:HORNER_STEPS-1];
  logic signed [31:0] tt_c;
  logic signed [31:0] mu_c;
  logic               mu_valid;
  logic signed [31:0] mu;

  function automatic logic [41:0] zdiv_step(input logic [41:0] st, input logic [9:0] d);
    logic [9:0]  rem;
    logic [31:0] nq;
    logic [10:0] r;
    rem = st[41:32];
    nq = st[31:0];
    for (int k = 0; k < 4; k++) begin
      r = {rem, nq[31]};
      nq = {nq[30:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        nq[0] = 1'b1;
      end
      rem = r[9:0];
    end
    return {rem, nq};
  endfunction

  function automatic logic [31:0] h_mul(input logic [31:0] y, input logic [30:0] t,
                                        input int s);
    logic [63:0] p;
    p = (64'(y) * 64'(t)) >> 30;
    return p[31:0] + 32'(horner_div(s) >> 1);
  endfunction

  function automatic logic [31:0] h_quo(input logic [31:0] x, input int s);
    logic [63:0] m;
    m = 64'(x) * 64'(horner_recip(s));
    return m[63:32];
  endfunction

  function automatic logic [30:0] h_fix(input logic [31:0] x, input logic [31:0] q,
                                        input int s);
    logic [39:0] r;
    logic [31:0] qq;
    r = 40'(x) - 40'(q) * 40'(horner_div(s));
    qq = q + 32'(r >= 40'(horner_div(s)));
    return (qq >= 32'(ONE_Q30)) ? 31'd0 : ONE_Q30 - qq[30:0];
  endfunction

  always_comb begin
    idx_c = (index > last) ? last : index;
    neg_c = ({idx_c, 1'b0} > {1'b0, last});
    fold_c = neg_c ? (last - idx_c) : idx_c;
    num_c = 42'(PI_Q30) * 42'(fold_c) + 42'(last[9:1]);
    zz_c = 64'(dv_st[DIV_STAGES][31:0]) * 64'(dv_st[DIV_STAGES][31:0]);
    tt_c = $signed({1'b0, hc_t[HORNER_STEPS-1]});
    mu_c = hc_neg[HORNER_STEPS-1] ? -tt_c : tt_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DIV_STAGES; j++) dv_valid[j] <= 1'b0;
      y_valid <= 1'b0;
      for (int s = 0; s < HORNER_STEPS; s++) begin
        ha_valid[s] <= 1'b0;
        hb_valid[s] <= 1'b0;
        hc_valid[s] <= 1'b0;
      end
      mu_valid <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= in_valid;
      for (int j = 1; j <= DIV_STAGES; j++) dv_valid[j] <= dv_valid[j-1];
      y_valid <= dv_valid[DIV_STAGES];
      for (int s = 0; s < HORNER_STEPS; s++) begin
        if (s == 0) ha_valid[s] <= y_valid;
        else ha_valid[s] <= hc_valid[s-1];
        hb_valid[s] <= ha_valid[s];
        hc_valid[s] <= hb_valid[s];
      end
      mu_valid <= hc_valid[HORNER_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_st[0] <= num_c;
      dv_neg[0] <= neg_c;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        dv_st[j] <= zdiv_step(dv_st[j-1], last);
        dv_neg[j] <= dv_neg[j-1];
      end
      y_val <= 32'((zz_c + 64'd536870912) >> 30);
      y_neg <= dv_neg[DIV_STAGES];
      for (int s = 0; s < HORNER_STEPS; s++) begin
        if (s == 0) begin
          ha_x[s] <= h_mul(y_val, ONE_Q30, s);
          ha_y[s] <= y_val;
          ha_neg[s] <= y_neg;
        end else begin
          ha_x[s] <= h_mul(hc_y[s-1], hc_t[s-1], s);
          ha_y[s] <= hc_y[s-1];
          ha_neg[s] <= hc_neg[s-1];
        end
        hb_q[s] <= h_quo(ha_x[s], s);
        hb_x[s] <= ha_x[s];
        hb_y[s] <= ha_y[s];
        hb_neg[s] <= ha_neg[s];
        hc_t[s] <= h_fix(hb_x[s], hb_q[s], s);
        hc_y[s] <= hb_y[s];
        hc_neg[s] <= hb_neg[s];
      end
      mu <= mu_c;
    end
  end

  assign angle = '{valid: mu_valid, mu: mu};

endmodule

[hw/rtl/sphf_lobe.sv]
// ---------------------------------------------------------------------------
// Phase lobe pipeline
// Computes one Henyey-Greenstein or Cornette-Shanks lobe from g and the cosine.
// ---------------------------------------------------------------------------
module sphf_lobe (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  sphf_pkg::angle_t   angle,
  input  logic signed [15:0] g,
  input  logic               cs,
  output sphf_pkg::lobe_t    lobe
);
  import sphf_pkg::*;

  logic               vld [1:LOBE_LAT];
  logic signed [31:0] gg_c;
  logic signed [47:0] gmu_c;
  logic [30:0]        mabs_c;
  logic [30:0]        gg1;
  logic signed [47:0] gmu1;
  logic [61:0]        mu2_1;
  logic signed [48:0] d45_c;
  logic [47:0]        d45u_c;
  logic [32:0]        dq2;
  logic [30:0]        n2;
  logic [31:0]        e2;
  logic [31:0]        f2;
  logic [62:0]        ne_c;
  logic [95:0]        sq_st [3:18];
  logic [32:0]        sq_dq [3:18];
  logic [63:0]        wd_st [3:19];
  logic [31:0]        wd_f  [3:19];
  logic [59:0]        hg_a  [3:19];
  logic [64:0]        p_c;
  logic [63:0]        p19;
  logic [60:0]        wa_c;
  logic [59:0]        a20;
  logic [63:0]        p20;
  logic               ovf_c;
  logic [111:0]       dc_st  [21:45];
  logic [63:0]        dc_p   [21:45];
  logic               dc_ovf [21:45];
  logic [47:0]        value;

  function automatic logic [95:0] sq_step(input logic [95:0] st, input int j);
    logic [63:0] rem;
    logic [31:0] root;
    logic [63:0] test;
    int          k;
    rem = st[95:32];
    root = st[31:0];
    for (int i = 0; i < 2; i++) begin
      k = 31 - 2 * j - i;
      test = (64'(root) << (k + 1)) | (64'd1 << (2 * k));
      if (rem >= test) begin
        rem = rem - test;
        root = root | (32'd1 << k);
      end
    end
    return {rem, root};
  endfunction

  function automatic logic [63:0] wd_step(input logic [63:0] st, input logic [31:0] f);
    logic [31:0] rem;
    logic [31:0] nq;
    logic [32:0] r;
    rem = st[63:32];
    nq = st[31:0];
    for (int i = 0; i < 2; i++) begin
      r = {rem, nq[31]};
      nq = {nq[30:0], 1'b0};
      if (r >= {1'b0, f}) begin
        r = r - {1'b0, f};
        nq[0] = 1'b1;
      end
      rem = r[31:0];
    end
    return {rem, nq};
  endfunction

  function automatic logic [111:0] dc_step(input logic [111:0] st, input logic [63:0] p);
    logic [63:0] rem;
    logic [47:0] nq;
    logic [64:0] r;
    rem = st[111:48];
    nq = st[47:0];
    for (int i = 0; i < 2; i++) begin
      r = {rem, nq[47]};
      nq = {nq[46:0], 1'b0};
      if (r >= {1'b0, p}) begin
        r = r - {1'b0, p};
        nq[0] = 1'b1;
      end
      rem = r[63:0];
    end
    return {rem, nq};
  endfunction

  always_comb begin
    gg_c = g * g;
    gmu_c = g * angle.mu;
    mabs_c = angle.mu[31] ? 31'(-angle.mu) : 31'(angle.mu);
    d45_c = (49'sd1 <<< 45) + $signed({3'b000, gg1, 15'd0}) - $signed({gmu1, 1'b0});
    d45u_c = d45_c[48] ? 48'd0 : d45_c[47:0];
    ne_c = 63'(n2) * 63'(e2);
    p_c = 65'(sq_dq[18]) * 65'(sq_st[18][31:0]);
    wa_c = 61'(wd_st[19][31:0]) * 61'(C38PI_Q32);
    ovf_c = (p20 == 64'd0) || (64'(a20[59:33]) >= p20);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LOBE_LAT; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[1] <= angle.valid;
      for (int s = 2; s <= LOBE_LAT; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gg1 <= gg_c[30:0];
      gmu1 <= gmu_c;
      mu2_1 <= 62'(mabs_c) * 62'(mabs_c);

      dq2 <= 33'((49'(d45u_c) + 49'd16384) >> 15);
      n2 <= ONE_Q30 - gg1;
      e2 <= 32'(ONE_Q30) + 32'((mu2_1 + 62'd536870912) >> 30);
      f2 <= 32'h8000_0000 + 32'(gg1);

      sq_st[3] <= sq_step({1'b0, dq2, 30'd0, 32'd0}, 0);
      sq_dq[3] <= dq2;
      for (int s = 4; s <= 18; s++) begin
        sq_st[s] <= sq_step(sq_st[s-1], s - 3);
        sq_dq[s] <= sq_dq[s-1];
      end

      wd_st[3] <= 64'(ne_c) + 64'(f2 >> 1);
      wd_f[3] <= f2;
      hg_a[3] <= 60'(n2) * 60'(INV4PI_Q32);
      for (int s = 4; s <= 19; s++) begin
        wd_st[s] <= wd_step(wd_st[s-1], wd_f[s-1]);
        wd_f[s] <= wd_f[s-1];
        hg_a[s] <= hg_a[s-1];
      end

      p19 <= p_c[63:0];
      a20 <= cs ? wa_c[59:0] : hg_a[19];
      p20 <= p19;

      dc_st[21] <= {64'(a20[59:33]), a20[32:0], 15'd0};
      dc_p[21] <= p20;
      dc_ovf[21] <= ovf_c;
      for (int s = 22; s <= 45; s++) begin
        dc_st[s] <= dc_step(dc_st[s-1], dc_p[s-1]);
        dc_p[s] <= dc_p[s-1];
        dc_ovf[s] <= dc_ovf[s-1];
      end

      value <= dc_ovf[45] ? LOBE_CAP : 48'((49'(dc_st[45][47:0]) + 49'd1) >> 1);
    end
  end

  assign lobe = '{valid: vld[LOBE_LAT], value: value};

endmodule

[hw/rtl/scattering_phase_function_eval_top.sv]
// ---------------------------------------------------------------------------
// Scattering phase function evaluator
// Evaluates a Cornette-Shanks, Henyey-Greenstein or double-lobe phase function.
// ---------------------------------------------------------------------------
// Usage: an item (angle_index, g_first, g_second, blend) enters when item_valid
// is high and item_stall is low. Each item gives one result (phase in unsigned
// Q16.16 and a saturated flag) on the result channel, taken when result_valid
// is high and result_stall is low.
// The cosine pipeline (index fold, angle divider, Horner steps) feeds the lobe
// pipeline (square root, Cornette-Shanks divider and the final quotient
// divider), followed by the registered blend products and saturated output.
// One item is accepted per cycle while item_stall is low; the fully pipelined
// dividers and square root set the rate and retire one item per unfrozen cycle.
// Configuration (mode, theta_samples) is written through cfg_valid/cfg_ready,
// cfg_index and cfg_data while no items are in flight; cfg_ready is always high.
// Reset clears all valid bits and sets mode to Cornette-Shanks and
// theta_samples to 91. When the output register holds a result and the
// receiver stalls, the whole pipeline freezes and item_stall is raised.
// ---------------------------------------------------------------------------
module scattering_phase_function_eval_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [9:0]         angle_index,
  input  logic signed [15:0] g_first,
  input  logic signed [15:0] g_second,
  input  logic [15:0]        blend,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        phase,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import sphf_pkg::*;

  localparam int BLEND_DLY = COS_LAT + LOBE_LAT;

  mode_t              mode;
  logic [9:0]         theta_samples;
  logic [9:0]         ts_c;
  logic [10:0]        last_w;
  logic [9:0]         last_c;
  logic               en;
  logic [15:0]        w_c;
  logic signed [15:0] g1_dl [1:COS_LAT];
  logic signed [15:0] g2_dl [1:COS_LAT];
  logic [15:0]        w_dl  [1:BLEND_DLY];
  angle_t             angle;
  lobe_t              lobe0;
  lobe_t              lobe1;
  logic [15:0]        wb_c;
  logic               b1_valid;
  logic [39:0]        pah;
  logic [39:0]        pal;
  logic [39:0]        pbh;
  logic [39:0]        pbl;
  logic [47:0]        a1;
  logic [63:0]        sum_c;
  logic [48:0]        val_c;
  logic               sat_c;

  assign cfg_ready = 1'b1;
  assign en = !(result_valid && result_stall);
  assign item_stall = !en;

  always_comb begin
    ts_c = theta_samples;
    if (ts_c < TS_MIN) ts_c = TS_MIN;
    if (ts_c > TS_MAX) ts_c = TS_MAX;
    last_w = {ts_c, 1'b0} - 11'd2;
    last_c = last_w[9:0];
    w_c = (blend > 16'd32768) ? 16'd32768 : blend;
    wb_c = 16'd32768 - w_dl[BLEND_DLY];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CS;
      theta_samples <= TS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE) begin
        mode <= mode_t'(cfg_data[1:0]);
      end else if (cfg_index == REG_THETA_SAMPLES) begin
        theta_samples <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_dl[1] <= g_first;
      g2_dl[1] <= g_second;
      for (int k = 2; k <= COS_LAT; k++) begin
        g1_dl[k] <= g1_dl[k-1];
        g2_dl[k] <= g2_dl[k-1];
      end
      w_dl[1] <= w_c;
      for (int k = 2; k <= BLEND_DLY; k++) w_dl[k] <= w_dl[k-1];
    end
  end

  sphf_cos u_cos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item_valid),
    .index    (angle_index),
    .last     (last_c),
    .angle    (angle)
  );

  sphf_lobe u_lobe0 (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .angle (angle),
    .g     (g1_dl[COS_LAT]),
    .cs    (mode == MODE_CS),
    .lobe  (lobe0)
  );

  sphf_lobe u_lobe1 (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .angle (angle),
    .g     (g2_dl[COS_LAT]),
    .cs    (1'b0),
    .lobe  (lobe1)
  );

  always_comb begin
    sum_c = ((64'(pah) + 64'(pbh)) << 24) + 64'(pal) + 64'(pbl) + 64'd16384;
    val_c = 49'd0;
    unique case (mode)
      MODE_CS:   val_c = 49'(a1);
      MODE_HG:   val_c = 49'(a1);
      MODE_DHG:  val_c = sum_c[63:15];
      MODE_NONE: val_c = 49'd0;
    endcase
    sat_c = (val_c > 49'h0_FFFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= lobe0.valid;
      result_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pah <= 40'(w_dl[BLEND_DLY]) * 40'(lobe0.value[47:24]);
      pal <= 40'(w_dl[BLEND_DLY]) * 40'(lobe0.value[23:0]);
      pbh <= 40'(wb_c) * 40'(lobe1.value[47:24]);
      pbl <= 40'(wb_c) * 40'(lobe1.value[23:0]);
      a1 <= lobe0.value;
      phase <= sat_c ? 32'hFFFF_FFFF : val_c[31:0];
      saturated <= sat_c;
    end
  end

`ifndef SYNTH
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> phase == 32'hFFFF_FFFF)
    else $error("saturated result without full-scale phase");
  a_mode_none: assert property (@(posedge clk) disable iff (rst)
    result_valid && mode == MODE_NONE |-> phase == 32'd0 && !saturated)
    else $error("unused mode produced a nonzero result");
  a_lobe_align: assert property (@(posedge clk) disable iff (rst)
    lobe0.valid |-> lobe1.valid)
    else $error("lobe pipelines out of step");
  a_lobe_cap: assert property (@(posedge clk) disable iff (rst)
    lobe0.valid |-> lobe0.value <= LOBE_CAP)
    else $error("lobe value above cap");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

[dv/tb_scattering_phase_function_eval_top.sv]
// ---------------------------------------------------------------------------
// Phase function evaluator testbench
// Drives directed and random items through the evaluator in all three modes
// and several angle resolutions, with random gaps and stalls on both sides,
// and checks each result against an integer predictor of the phase function.
// ---------------------------------------------------------------------------
module tb_scattering_phase_function_eval_top;
  import sphf_pkg::*;

  localparam int PIPE_LAT = 83;

  typedef struct {
    logic [31:0] phase;
    logic        saturated;
  } phase_res_t;

  typedef struct {
    logic [9:0]  angle_index;
    logic [15:0] g_first;
    logic [15:0] g_second;
    logic [15:0] blend;
    logic        has_exp;
    logic [31:0] exp_phase;
    logic        exp_sat;
  } stim_row_t;

  logic clk, rst;
  logic item_valid, item_stall;
  logic [9:0] angle_index;
  logic signed [15:0] g_first, g_second;
  logic [15:0] blend;
  logic result_valid, result_stall;
  logic [31:0] phase;
  logic saturated;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  scattering_phase_function_eval_top u_top (.*);

  phase_res_t expected_phases[$];
  int n_errors;
  int n_results;
  int n_sent;
  int send_idle_pct;
  int recv_stall_pct;
  logic [1:0] cur_mode;
  logic [9:0] cur_ts;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s at result %0d: got %0h expected %0h", what, n_results,
             got, want);
    n_errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cos_mu(input logic [63:0] i, input logic [63:0] last);
    logic neg;
    logic [63:0] z, y, t, p, d;
    neg = 1'b0;
    if (2 * i > last) begin
      i = last - i;
      neg = 1'b1;
    end
    z = (64'(PI_Q30) * i + last / 2) / last;
    y = (z * z + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    for (int n = 16; n >= 2; n -= 2) begin
      d = n * (n - 1);
      p = (y * t) >> 30;
      p = (p + d / 2) / d;
      t = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
    end
    return neg ? -longint'(t) : longint'(t);
  endfunction

  function automatic logic [63:0] denom_pow(input longint g, input longint mu);
    longint d45;
    logic [63:0] dq;
    d45 = (longint'(1) << 45) + g * g * 32768 - 2 * g * mu;
    if (d45 < 0) d45 = 0;
    dq = (64'(d45) + (64'd1 << 14)) >> 15;
    return dq * int_sqrt(dq << 30);
  endfunction

  function automatic logic [63:0] quot_cap(input logic [63:0] a, input logic [63:0] p);
    logic [63:0] q, r;
    if (p == 0) return 64'(LOBE_CAP);
    q = a / p;
    if (q >= (64'd1 << 33)) return 64'(LOBE_CAP);
    r = a % p;
    for (int k = 0; k < 15; k++) begin
      r <<= 1;
      q <<= 1;
      if (r >= p) begin
        r -= p;
        q |= 1;
      end
    end
    q = (q + 1) >> 1;
    return q > 64'(LOBE_CAP) ? 64'(LOBE_CAP) : q;
  endfunction

  function automatic logic [63:0] hg_value(input longint g, input longint mu);
    logic [63:0] n;
    n = (64'd1 << 30) - 64'(g * g);
    return quot_cap(n * 64'(INV4PI_Q32), denom_pow(g, mu));
  endfunction

  function automatic logic [63:0] cs_phase(input longint g, input longint mu);
    logic [63:0] n, am, e, f, w;
    n = (64'd1 << 30) - 64'(g * g);
    am = 64'(mu < 0 ? -mu : mu);
    e = (64'd1 << 30) + ((am * am + (64'd1 << 29)) >> 30);
    f = (64'd1 << 31) + 64'(g * g);
    w = (n * e + f / 2) / f;
    return quot_cap(w * 64'(C38PI_Q32), denom_pow(g, mu));
  endfunction

  function automatic phase_res_t predict_phase(input logic [9:0] ai,
      input logic [15:0] g1r, input logic [15:0] g2r, input logic [15:0] bl);
    logic [63:0] ts, last, idx, v, w, a, b;
    longint g1, g2, mu;
    phase_res_t res;
    ts = cur_ts;
    if (ts < 2) ts = 2;
    if (ts > (MAX_ANGLES + 1) / 2) ts = (MAX_ANGLES + 1) / 2;
    last = 2 * ts - 2;
    idx = ai;
    if (idx > last) idx = last;
    g1 = longint'($signed(g1r));
    g2 = longint'($signed(g2r));
    w = bl;
    if (w > 32768) w = 32768;
    mu = cos_mu(idx, last);
    case (mode_t'(cur_mode))
      MODE_CS: v = cs_phase(g1, mu);
      MODE_HG: v = hg_value(g1, mu);
      MODE_DHG: begin
        a = hg_value(g1, mu);
        b = hg_value(g2, mu);
        v = (w * a + (32768 - w) * b + 16384) >> 15;
      end
      default: v = 0;
    endcase
    if (v > 64'hFFFF_FFFF) begin
      res.phase = 32'hFFFF_FFFF;
      res.saturated = 1'b1;
    end else begin
      res.phase = v[31:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  // Result side: random stalls, compare with the oldest expectation.
  always @(posedge clk) begin
    phase_res_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_phases.size() == 0) begin
        report_mismatch("unexpected item", {32'd0, phase}, 64'd0);
      end else begin
        want = expected_phases.pop_front();
        if (phase !== want.phase) report_mismatch("phase", 64'(phase), 64'(want.phase));
        if (saturated !== want.saturated)
          report_mismatch("saturated", 64'(saturated), 64'(want.saturated));
      end
      n_results++;
    end
  end

  always @(negedge clk) begin
    result_stall <= (!rst && $urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MODE) cur_mode = val[1:0];
    else if (idx == REG_THETA_SAMPLES) cur_ts = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (expected_phases.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_item(input logic [9:0] ai, input logic [15:0] g1,
                           input logic [15:0] g2, input logic [15:0] bl);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    angle_index <= ai;
    g_first <= g1;
    g_second <= g2;
    blend <= bl;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_phases.push_back(predict_phase(ai, g1, g2, bl));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    item_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_g();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(65535));
      3: return 16'($urandom_range(2000) - 1000);
      default: return 16'($urandom_range(60000) - 30000);
    endcase
  endfunction

  function automatic logic [15:0] rand_blend();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [9:0] rand_index();
    logic [9:0] last;
    last = 10'(2 * (cur_ts < 2 ? 2 : (cur_ts > TS_MAX ? TS_MAX : cur_ts)) - 2);
    case ($urandom_range(4))
      0: return 10'($urandom_range(1023));
      1: return last;
      2: return 10'd0;
      default: return 10'($urandom_range(last));
    endcase
  endfunction

  stim_row_t directed_rows[$];

  initial begin
    stim_row_t row;
    phase_res_t got;
    int per_phase;
    int ts_list[6];
    n_errors = 0;
    n_results = 0;
    n_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_mode = MODE_CS;
    cur_ts = TS_RESET;
    rst = 1'b1;
    item_valid = 1'b0;
    angle_index = '0;
    g_first = '0;
    g_second = '0;
    blend = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows, run at reset settings (Cornette-Shanks, 91 samples).
    // In mode 3 the row predictions are checked below for a zero, unsaturated result.
    directed_rows = '{
      '{10'd0, 16'h0000, 16'h0000, 16'd0, 1'b0, 32'd0, 1'b0},
      '{10'd90, 16'h0000, 16'h0000, 16'd0, 1'b0, 32'd0, 1'b0},
      '{10'd180, 16'h0000, 16'h0000, 16'd0, 1'b0, 32'd0, 1'b0},
      '{10'd1022, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 32'd0, 1'b0},
      '{10'd1023, 16'h8000, 16'h7FFF, 16'd32768, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{10'd0, 16'h7FFF, 16'h0000, 16'd0, 1'b0, 32'd0, 1'b0},
      '{10'd0, 16'h8000, 16'h0000, 16'd0, 1'b0, 32'd0, 1'b0},
      '{10'd45, 16'h4000, 16'hC000, 16'd16384, 1'b0, 32'd0, 1'b0},
      '{10'd200, 16'hFFFF, 16'h0001, 16'h8001, 1'b0, 32'd0, 1'b0}
    };
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_item(row.angle_index, row.g_first, row.g_second, row.blend);
      if (row.has_exp) begin
        got = expected_phases[expected_phases.size() - 1];
        if (got.phase !== row.exp_phase || got.saturated !== row.exp_sat)
          report_mismatch("directed row", 64'(got.phase), 64'(row.exp_phase));
      end
    end
    end_burst();
    drain_pipeline();

    for (int m = MODE_HG; m <= MODE_NONE; m++) begin
      write_reg(REG_MODE, 10'(m));
      foreach (directed_rows[k]) begin
        row = directed_rows[k];
        send_item(row.angle_index, row.g_first, row.g_second, row.blend);
        got = expected_phases[expected_phases.size() - 1];
        if (m == MODE_NONE && (got.phase !== 32'd0 || got.saturated !== 1'b0))
          report_mismatch("unused mode", 64'(got.phase), 64'd0);
      end
      end_burst();
      drain_pipeline();
    end
    // Degenerate lobe with zero weight stays finite.
    write_reg(REG_MODE, 10'(MODE_DHG));
    send_item(10'd180, 16'h8000, 16'h2000, 16'd0);
    send_item(10'd180, 16'h2000, 16'h8000, 16'd32768);
    end_burst();
    drain_pipeline();

    // Random part: several resolutions, every idling profile.
    ts_list = '{2, 512, 0, 1023, 91, 7};
    per_phase = 1900 / (6 * 4);
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_THETA_SAMPLES, 10'(ts_list[s]));
      for (int p = 0; p < 4; p++) begin
        write_reg(REG_MODE, 10'($urandom_range(s == 5 ? 3 : 2)));
        case (p)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 72; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 72; end
          default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
        for (int k = 0; k < per_phase; k++) begin
          send_item(rand_index(), rand_g(), rand_g(), rand_blend());
          if (k == per_phase / 2 && p == 2) begin
            item_valid <= 1'b0;
            while (expected_phases.size() != 0) @(negedge clk);
          end
        end
        end_burst();
        drain_pipeline();
      end
    end
    recv_stall_pct = 0;
    drain_pipeline();

    $display("Covered %0d items and %0d results over all modes, theta_samples 0 to 1023,",
             n_sent, n_results);
    $display("with sender gaps and receiver stalls in every combination.");
    if (n_errors == 0 && expected_phases.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/sphf_pkg.sv
hw/rtl/sphf_cos.sv
hw/rtl/sphf_lobe.sv
hw/rtl/scattering_phase_function_eval_top.sv
dv/tb_scattering_phase_function_eval_top.sv
